>>> rtl/sam_pkg.sv
package sam_pkg;

    localparam int SampleBitsDef = 16;
    localparam int AccW          = 40;
    localparam int CoordW        = 24;
    localparam int GainW         = 16;
    localparam int QueueDepth    = 2;

    localparam logic [1:0] TypeMusic  = 2'd0;
    localparam logic [1:0] TypeEffect = 2'd1;
    localparam logic [1:0] TypeSpeech = 2'd2;

    localparam logic [1:0] RegWMusic  = 2'd0;
    localparam logic [1:0] RegWEffect = 2'd1;
    localparam logic [1:0] RegWSpeech = 2'd2;
    localparam logic [1:0] RegOutCh   = 2'd3;

    // 1e6 * 65536, distance gain dividend
    localparam logic [35:0] DistNum    = 36'd65536000000;
    localparam logic [49:0] DistOne    = 50'd1000000;
    localparam logic [16:0] DistOffset = 17'd6554;
    localparam logic [25:0] PanNum     = 26'd32768000;

endpackage

>>> rtl/sam_divider.sv
// Restoring unsigned divider, one quotient bit per cycle.
module sam_divider import sam_pkg::*; #(
    parameter int NumW = 36,
    parameter int DenW = 50
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [NumW-1:0] num,
    input  logic [DenW-1:0] den,
    output logic            done,
    output logic [NumW-1:0] quot
);

    localparam int CntW = $clog2(NumW + 1);

    logic [NumW-1:0] q_reg;
    logic [DenW:0]   rem_reg;
    logic [DenW-1:0] den_reg;
    logic [CntW-1:0] cnt_reg;
    logic            busy_reg;
    logic            done_reg;
    logic [DenW:0]   shifted;
    logic [DenW:0]   diff;

    assign shifted = {rem_reg[DenW-1:0], q_reg[NumW-1]};
    assign diff    = shifted - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CntW'(NumW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CntW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            if (!diff[DenW])
            begin
                rem_reg <= diff;
                q_reg   <= {q_reg[NumW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted;
                q_reg   <= {q_reg[NumW-2:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

>>> rtl/sam_front.sv
// Front end: takes beats, computes base gain and offsets, queues items.
module sam_front import sam_pkg::*; #(
    parameter int SampleBits = SampleBitsDef,
    parameter int ItemW      = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [1:0]       source_type,
    input  logic [15:0]      volume,
    input  logic [CoordW-1:0] sx,
    input  logic [CoordW-1:0] sy,
    input  logic [CoordW-1:0] lx,
    input  logic [CoordW-1:0] ly,
    input  logic [1:0]       src_ch,
    input  logic [SampleBits-1:0] sl,
    input  logic [SampleBits-1:0] sr,
    input  logic             last,
    input  logic [15:0]      w_music,
    input  logic [15:0]      w_effect,
    input  logic [15:0]      w_speech,
    output logic             q_valid,
    input  logic             q_ready,
    output logic [ItemW-1:0] q_data
);

    // item: last, sr, sl, src_ch, dy, dx, effect, g
    logic [15:0]        weight;
    logic [31:0]        prod;
    logic [CoordW:0]    dx;
    logic [CoordW:0]    dy;
    logic [ItemW-1:0]   item;
    logic [ItemW-1:0]   mem_reg [QueueDepth];
    logic [0:0]         wp_reg;
    logic [0:0]         rp_reg;
    logic [1:0]         cnt_reg;
    logic               push;
    logic               pop;

    always_comb
    begin
        case (source_type)
            TypeMusic:  weight = w_music;
            TypeEffect: weight = w_effect;
            TypeSpeech: weight = w_speech;
            default:    weight = '0;
        endcase
    end

    assign prod = weight * volume;
    assign dx   = {sx[CoordW-1], sx} - {lx[CoordW-1], lx};
    assign dy   = {sy[CoordW-1], sy} - {ly[CoordW-1], ly};
    assign item = {last, sr, sl, src_ch, dy, dx, source_type == TypeEffect, prod[31:16]};

    assign in_ready = cnt_reg != 2'd2;
    assign push     = in_valid && in_ready;
    assign q_valid  = cnt_reg != 2'd0;
    assign pop      = q_valid && q_ready;
    assign q_data   = mem_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= wp_reg + 1'b1;
            if (pop)
                rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= item;
    end

endmodule

>>> rtl/sam_back.sv
// Back end: distance gain, pan, accumulation and frame output.
module sam_back import sam_pkg::*; #(
    parameter int SampleBits = SampleBitsDef,
    parameter int ItemW      = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    output logic             q_ready,
    input  logic [ItemW-1:0] q_data,
    input  logic [1:0]       out_ch,
    output logic             o_valid,
    input  logic             o_ready,
    output logic [SampleBits-1:0] o_left,
    output logic [SampleBits-1:0] o_right,
    output logic             o_clip
);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_SQ    = 9'b000000010,
        S_DDIV  = 9'b000000100,
        S_DG    = 9'b000001000,
        S_PL    = 9'b000010000,
        S_PR    = 9'b000100000,
        S_MUL   = 9'b001000000,
        S_ACC   = 9'b010000000,
        S_OUT   = 9'b100000000
    } state_t;

    localparam int DW = CoordW + 1;
    localparam int SqW = 2 * DW;
    localparam logic signed [AccW-1:0] AccMax = {1'b0, {(AccW-1){1'b1}}};
    localparam logic signed [AccW-1:0] AccMin = {1'b1, {(AccW-1){1'b0}}};
    localparam int OutHiW = AccW - 16;

    state_t state_reg;
    logic [ItemW-1:0] it_reg;
    logic [15:0] g;
    logic eff;
    logic signed [DW-1:0] dx;
    logic [1:0] sch;
    logic signed [SampleBits-1:0] sl;
    logic signed [SampleBits-1:0] sr;
    logic last;

    assign g   = it_reg[15:0];
    assign eff = it_reg[16];
    assign dx  = it_reg[17 +: DW];
    assign sch = it_reg[17+2*DW +: 2];
    assign sl  = it_reg[19+2*DW +: SampleBits];
    assign sr  = it_reg[19+2*DW+SampleBits +: SampleBits];
    assign last = it_reg[19+2*DW+2*SampleBits];

    logic [SqW-1:0] sqx_reg;
    logic [SqW-1:0] sqy_reg;
    logic [15:0] gl_reg;
    logic [15:0] gr_reg;
    logic [16:0] dw_reg;
    logic [15:0] geff_reg;
    logic signed [SampleBits+16:0] pl_reg;
    logic signed [SampleBits+16:0] pr_reg;
    logic signed [AccW-1:0] accl_reg;
    logic signed [AccW-1:0] accr_reg;
    logic [SampleBits-1:0] ol_reg;
    logic [SampleBits-1:0] or_reg;
    logic clip_reg;
    logic pan_right_reg;
    logic [1:0] oc;
    logic [1:0] sc;
    logic [1:0] common;

    assign oc = (out_ch == 2'd3) ? 2'd2 : out_ch;
    assign sc = (sch == 2'd3) ? 2'd2 : sch;
    assign common = (sc < oc) ? sc : oc;

    // squares of the queue head offsets, registered while idle
    logic signed [DW-1:0]  hx;
    logic signed [DW-1:0]  hy;
    logic signed [SqW-1:0] sqx_c;
    logic signed [SqW-1:0] sqy_c;
    assign hx    = q_data[17 +: DW];
    assign hy    = q_data[17+DW +: DW];
    assign sqx_c = hx * hx;
    assign sqy_c = hy * hy;

    // shared divider: distance gain, then the two pan terms
    logic dstart;
    logic [49:0] dnum;
    logic [49:0] dden;
    logic ddone;
    logic [49:0] dq;

    sam_divider #(.NumW(50), .DenW(50)) u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .start(dstart),
        .num  (dnum),
        .den  (dden),
        .done (ddone),
        .quot (dq)
    );

    logic signed [DW:0] px;
    logic [DW:0] pmag;
    assign px   = pan_right_reg ? -{dx[DW-1], dx} : {dx[DW-1], dx};
    assign pmag = px[DW] ? (-px) : px;

    always_comb
    begin
        dstart = 1'b0;
        dnum   = 50'(PanNum);
        dden   = 50'(pmag) + 50'd1000;
        case (state_reg)
            S_SQ:
            begin
                dstart = 1'b1;
                dnum   = 50'(DistNum);
                dden   = DistOne + 50'(sqx_reg) + 50'(sqy_reg);
            end
            S_DG:    dstart = 1'b1;
            S_PL:    dstart = ddone;
            default: dstart = 1'b0;
        endcase
    end

    // pan gain from quotient
    logic [16:0] pan;
    always_comb
    begin
        if (!px[DW])
            pan = (dq > 50'd65535) ? 17'd65535 : dq[16:0];
        else
            pan = 17'd65536 - dq[16:0];
        if (pan > 17'd65535)
            pan = 17'd65535;
    end

    logic [31:0] gp;
    assign gp = geff_reg * pan[15:0];

    // saturating accumulate
    logic signed [AccW:0] suml;
    logic signed [AccW:0] sumr;
    assign suml = {accl_reg[AccW-1], accl_reg} + (AccW+1)'(pl_reg);
    assign sumr = {accr_reg[AccW-1], accr_reg} + (AccW+1)'(pr_reg);

    function automatic logic signed [AccW-1:0] sat(input logic signed [AccW:0] v);
        logic signed [AccW-1:0] r;
        if (v > (AccW+1)'(AccMax))
            r = AccMax;
        else if (v < (AccW+1)'(AccMin))
            r = AccMin;
        else
            r = v[AccW-1:0];
        return r;
    endfunction

    logic signed [AccW-1:0] nl;
    logic signed [AccW-1:0] nr;
    assign nl = (common >= 2'd1) ? sat(suml) : accl_reg;
    assign nr = (common >= 2'd2) ? sat(sumr) : accr_reg;

    // output rounding: floor shift, then saturate
    localparam logic signed [OutHiW-1:0] OHi = OutHiW'((1 << (SampleBits - 1)) - 1);
    localparam logic signed [OutHiW-1:0] OLo = -OHi - 1'b1;
    logic signed [OutHiW-1:0] hl;
    logic signed [OutHiW-1:0] hr;
    logic cl;
    logic cr;
    assign hl = nl[AccW-1:16];
    assign hr = nr[AccW-1:16];
    assign cl = (hl > OHi) || (hl < OLo);
    assign cr = (hr > OHi) || (hr < OLo);

    logic [SampleBits-1:0] vl;
    logic [SampleBits-1:0] vr;
    assign vl = (hl > OHi) ? OHi[SampleBits-1:0] : (hl < OLo) ? OLo[SampleBits-1:0]
              : hl[SampleBits-1:0];
    assign vr = (hr > OHi) ? OHi[SampleBits-1:0] : (hr < OLo) ? OLo[SampleBits-1:0]
              : hr[SampleBits-1:0];

    assign q_ready = state_reg == S_IDLE;
    assign o_valid = state_reg == S_OUT;
    assign o_left  = ol_reg;
    assign o_right = or_reg;
    assign o_clip  = clip_reg;

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            accl_reg  <= '0;
            accr_reg  <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                    if (q_valid)
                        state_reg <= S_SQ;
                S_SQ:
                    state_reg <= eff ? S_DDIV : S_MUL;
                S_DDIV:
                    if (ddone)
                        state_reg <= S_DG;
                S_DG:
                    state_reg <= S_PL;
                S_PL:
                    if (ddone)
                        state_reg <= S_PR;
                S_PR:
                    if (ddone)
                        state_reg <= S_MUL;
                S_MUL:
                    state_reg <= S_ACC;
                S_ACC:
                begin
                    if (last)
                    begin
                        accl_reg  <= '0;
                        accr_reg  <= '0;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        accl_reg  <= nl;
                        accr_reg  <= nr;
                        state_reg <= S_IDLE;
                    end
                end
                S_OUT:
                    if (o_ready)
                        state_reg <= S_IDLE;
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                it_reg <= q_data;
                pan_right_reg <= 1'b0;
            end
            S_SQ:
            begin
                gl_reg <= g;
                gr_reg <= g;
            end
            S_DDIV:
                if (ddone)
                    dw_reg <= (dq > 50'(DistOffset)) ? 17'(dq - 50'(DistOffset)) : '0;
            S_DG:
                geff_reg <= 16'((32'(g) * 32'(dw_reg)) >> 16);
            S_PL:
                if (ddone)
                begin
                    gl_reg <= gp[31:16];
                    pan_right_reg <= 1'b1;
                end
            S_PR:
                if (ddone)
                    gr_reg <= gp[31:16];
            S_MUL:
            begin
                pl_reg <= sl * $signed({1'b0, gl_reg});
                pr_reg <= sr * $signed({1'b0, gr_reg});
            end
            S_ACC:
            begin
                ol_reg   <= (oc >= 2'd1) ? vl : '0;
                or_reg   <= (oc >= 2'd2) ? vr : '0;
                clip_reg <= ((oc >= 2'd1) && cl) || ((oc >= 2'd2) && cr);
            end
            default:
            begin
            end
        endcase
        if (state_reg == S_IDLE)
        begin
            sqx_reg <= sqx_c;
            sqy_reg <= sqy_c;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        o_valid && !o_ready |=> o_valid && $stable(o_left))
        else $error("result changed while stalled");
    assert property (@(posedge clk) disable iff (!rst_n)
        q_valid && q_ready |=> state_reg == S_SQ)
        else $error("item not started");
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("state not one-hot");

endmodule

>>> rtl/spatial_audio_mixer_unit.sv
// Channel   Dir  Payload
// s_axis    in   tdata: type,volume,sx,sy,lx,ly,src_ch,sl,sr ; tlast: last_source
// m_axis    out  tdata: mix_left,mix_right,clipped
// cfg       in   cfg_we / cfg_index / cfg_data
// Music/speech items pass through S_SQ, S_MUL and S_ACC in the back end; effect items
// also run three 50-step divisions on the shared divider. A frame result then
// waits in the output state.
// A two-entry queue lets the front accept beats while the back works.
// Reset clears accumulators, queue and state; registers take defaults.
// A frame result holds in the back end until m_axis_tready.
module spatial_audio_mixer_unit import sam_pkg::*; #(
    parameter int SampleBits = SampleBitsDef
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // type[1:0], volume, source_x, source_y, listener_x, listener_y,
    // source_channels, sample_left, sample_right, zero fill
    input  logic [((2+16+4*CoordW+2+2*SampleBits+7)/8)*8-1:0] s_axis_tdata,
    input  logic s_axis_tlast,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // mix_left, mix_right, clipped, zero fill
    output logic [((2*SampleBits+1+7)/8)*8-1:0] m_axis_tdata,
    input  logic cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int OutW  = ((2*SampleBits+1+7)/8)*8;
    localparam int ItemW = 20 + 2*(CoordW+1) + 2*SampleBits;

    logic [15:0] w_music_reg;
    logic [15:0] w_effect_reg;
    logic [15:0] w_speech_reg;
    logic [1:0]  out_ch_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_music_reg  <= 16'd22938;
            w_effect_reg <= 16'd13107;
            w_speech_reg <= 16'd29491;
            out_ch_reg   <= 2'd2;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                RegWMusic:  w_music_reg  <= cfg_data;
                RegWEffect: w_effect_reg <= cfg_data;
                RegWSpeech: w_speech_reg <= cfg_data;
                RegOutCh:   out_ch_reg   <= cfg_data[1:0];
                default:    out_ch_reg   <= out_ch_reg;
            endcase
        end
    end

    logic q_valid;
    logic q_ready;
    logic [ItemW-1:0] q_data;
    logic [SampleBits-1:0] ol;
    logic [SampleBits-1:0] orr;
    logic oclip;

    sam_front #(.SampleBits(SampleBits), .ItemW(ItemW)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .source_type(s_axis_tdata[1:0]),
        .volume     (s_axis_tdata[17:2]),
        .sx         (s_axis_tdata[18 +: CoordW]),
        .sy         (s_axis_tdata[18+CoordW +: CoordW]),
        .lx         (s_axis_tdata[18+2*CoordW +: CoordW]),
        .ly         (s_axis_tdata[18+3*CoordW +: CoordW]),
        .src_ch     (s_axis_tdata[18+4*CoordW +: 2]),
        .sl         (s_axis_tdata[20+4*CoordW +: SampleBits]),
        .sr         (s_axis_tdata[20+4*CoordW+SampleBits +: SampleBits]),
        .last       (s_axis_tlast),
        .w_music    (w_music_reg),
        .w_effect   (w_effect_reg),
        .w_speech   (w_speech_reg),
        .q_valid    (q_valid),
        .q_ready    (q_ready),
        .q_data     (q_data)
    );

    sam_back #(.SampleBits(SampleBits), .ItemW(ItemW)) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_valid(q_valid),
        .q_ready(q_ready),
        .q_data (q_data),
        .out_ch (out_ch_reg),
        .o_valid(m_axis_tvalid),
        .o_ready(m_axis_tready),
        .o_left (ol),
        .o_right(orr),
        .o_clip (oclip)
    );

    assign m_axis_tdata = OutW'({oclip, orr, ol});

endmodule

>>> tb/tb_spatial_audio_mixer_unit.sv
`timescale 1ns / 1ps

module tb_spatial_audio_mixer_unit;
    import sam_pkg::*;

    localparam int SB     = SampleBitsDef;
    localparam int InW    = ((2+16+4*CoordW+2+2*SB+7)/8)*8;
    localparam int OutW   = ((2*SB+1+7)/8)*8;
    localparam int IdleLimit = 20000;
    localparam logic signed [63:0] AccMax = 64'sd549755813887;
    localparam logic signed [63:0] AccMin = -64'sd549755813888;

    typedef struct packed {
        logic [1:0]         stype;
        logic [15:0]        vol;
        logic signed [23:0] sx;
        logic signed [23:0] sy;
        logic signed [23:0] lx;
        logic signed [23:0] ly;
        logic [1:0]         sch;
        logic signed [15:0] sl;
        logic signed [15:0] sr;
        logic               last;
    } src_item_t;

    typedef struct packed {
        logic signed [15:0] ml;
        logic signed [15:0] mr;
        logic               clip;
    } mix_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [InW-1:0] s_axis_tdata = '0;   // type, volume, sx, sy, lx, ly, src_ch, sl, sr
    logic s_axis_tlast = 1'b0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [OutW-1:0] m_axis_tdata;        // mix_left, mix_right, clipped
    logic cfg_we = 1'b0;
    logic [1:0] cfg_index = '0;
    logic [15:0] cfg_data = '0;

    spatial_audio_mixer_unit uut (.*);

    always #5 clk = ~clk;

    // mixer shadow state
    logic [15:0] w_music, w_effect, w_speech;
    logic [1:0]  n_out;
    logic signed [63:0] sum_l, sum_r;
    mix_t frames_due[$];
    int mismatches = 0, frames_seen = 0, beats_sent = 0, idle_cycles = 0;
    bit  quiet = 0;          // no idling near the end
    bit  hold_off = 0;       // long receiver stall
    bit  timed_out = 0;

    function automatic logic [16:0] pan_of(input logic signed [63:0] x);
        logic signed [63:0] q;
        if (x >= 0) q = 64'sd32768000 / (64'sd1000 + x);
        else q = 64'sd65536 - 64'sd32768000 / (64'sd1000 - x);
        if (q > 65535) q = 65535;
        return q[16:0];
    endfunction

    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] d);
        logic signed [63:0] s;
        s = a + d;
        if (s > AccMax) return AccMax;
        if (s < AccMin) return AccMin;
        return s;
    endfunction

    function automatic logic signed [15:0] round_out(input logic signed [63:0] a,
                                                     inout bit clip);
        logic signed [63:0] v;
        v = a >>> 16;   // arithmetic shift is floor
        if (v > 32767) begin v = 32767; clip = 1; end
        if (v < -32768) begin v = -32768; clip = 1; end
        return v[15:0];
    endfunction

    task automatic mix_source(input src_item_t it);
        logic [1:0] oc, sc, common;
        logic [63:0] wt, g, gl, gr, d2, q, dw;
        logic signed [63:0] dx, dy;
        mix_t r;
        bit clip;
        clip = 0;
        oc = (n_out > 2) ? 2'd2 : n_out;
        sc = (it.sch > 2) ? 2'd2 : it.sch;
        common = (sc < oc) ? sc : oc;
        case (it.stype)
            TypeMusic:  wt = 64'(w_music);
            TypeEffect: wt = 64'(w_effect);
            TypeSpeech: wt = 64'(w_speech);
            default:    wt = '0;
        endcase
        g = (wt * it.vol) >> 16;
        gl = g;
        gr = g;
        if (it.stype == TypeEffect) begin
            dx = 64'(it.sx) - 64'(it.lx);
            dy = 64'(it.sy) - 64'(it.ly);
            d2 = dx * dx + dy * dy;
            q = 64'd65536000000 / (64'd1000000 + d2);
            dw = (q > 6554) ? q - 6554 : 0;
            g = (g * dw) >> 16;
            gl = (g * pan_of(dx)) >> 16;
            gr = (g * pan_of(-dx)) >> 16;
        end
        if (common >= 1) sum_l = sat_add(sum_l, 64'(it.sl) * $signed(gl));
        if (common >= 2) sum_r = sat_add(sum_r, 64'(it.sr) * $signed(gr));
        if (it.last) begin
            r.ml = (oc >= 1) ? round_out(sum_l, clip) : '0;
            r.mr = (oc >= 2) ? round_out(sum_r, clip) : '0;
            r.clip = clip;
            frames_due.push_back(r);
            sum_l = 0;
            sum_r = 0;
        end
    endtask

    // directed table; expected typed in where obvious
    typedef struct {
        src_item_t it;
        bit        known;
        mix_t      want;
    } row_t;
    row_t dir_rows[$];

    function automatic src_item_t mk(input logic [1:0] t, input int v,
        input int sx, input int sy, input int lx, input int ly,
        input int ch, input int l, input int r, input int last);
        src_item_t s;
        s.stype = t; s.vol = 16'(v);
        s.sx = 24'(sx); s.sy = 24'(sy); s.lx = 24'(lx); s.ly = 24'(ly);
        s.sch = 2'(ch); s.sl = 16'(l); s.sr = 16'(r); s.last = (last != 0);
        return s;
    endfunction

    task automatic add_row(input src_item_t s, input int k = 0,
                           input mix_t w = '0);
        row_t r;
        r.it = s; r.known = (k != 0); r.want = w;
        dir_rows.push_back(r);
    endtask

    task automatic send(input src_item_t it);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        s_axis_tdata <= InW'({it.sr, it.sl, it.sch, it.ly, it.lx, it.sy, it.sx,
                              it.vol, it.stype});
        s_axis_tlast <= it.last;
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        mix_source(it);
        beats_sent++;
        @(negedge clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (frames_due.size() != 0) @(negedge clk);
        repeat (400) @(negedge clk);   // effect items may still be in the back end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            RegWMusic:  w_music = val;
            RegWEffect: w_effect = val;
            RegWSpeech: w_speech = val;
            default:    n_out = val[1:0];
        endcase
    endtask

    function automatic src_item_t rand_item(input int mode);
        src_item_t s;
        s.stype = $urandom_range(0, 9) == 0 ? 2'd3 : 2'($urandom_range(0, 2));
        s.vol = 16'($urandom);
        if (mode == 0) begin
            // near listener, so effects are audible
            s.lx = $signed(24'($urandom));
            s.ly = $signed(24'($urandom));
            s.sx = s.lx + $signed(24'($urandom_range(0, 4000))) - 24'sd2000;
            s.sy = s.ly + $signed(24'($urandom_range(0, 4000))) - 24'sd2000;
        end else begin
            s.sx = 24'($urandom); s.sy = 24'($urandom);
            s.lx = 24'($urandom); s.ly = 24'($urandom);
        end
        s.sch = $urandom_range(0, 9) == 0 ? 2'($urandom) : 2'($urandom_range(1, 2));
        s.sl = 16'($urandom);
        s.sr = 16'($urandom);
        s.last = ($urandom_range(0, 3) == 0);
        return s;
    endfunction

    // receiver: random stall bursts plus one long hold-off
    initial begin
        bit hold_done;
        hold_done = 0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (hold_off && !hold_done) begin
                // long stall so the queue fills and the input backs up
                m_axis_tready <= 1'b0;
                repeat (300) @(negedge clk);
                hold_done = 1;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(0, 2)) @(negedge clk);
            end else m_axis_tready <= 1'b1;
        end
    end

    // result checker
    always @(posedge clk) begin
        mix_t got, exp_r;
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            got = {m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tdata[32]};
            frames_seen++;
            if (frames_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected frame %h", got);
            end else begin
                exp_r = frames_due.pop_front();
                if (got !== exp_r) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("frame %0d: exp L=%0d R=%0d c=%b got L=%0d R=%0d c=%b",
                                 frames_seen, exp_r.ml, exp_r.mr, exp_r.clip,
                                 got.ml, got.mr, got.clip);
                end
            end
        end
    end

    // watchdog on cycles with no accepted beat
    always @(posedge clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else if (rst_n) idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IdleLimit && !timed_out) begin
            timed_out = 1;
            $display("[spatial_audio_mixer_unit] ERROR");
            $finish;
        end
    end

    initial begin
        mix_t w;
        w_music = 22938; w_effect = 13107; w_speech = 29491; n_out = 2;
        sum_l = 0; sum_r = 0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: zero samples give zero frame
        w = '0;
        add_row(mk(TypeMusic, 16'hFFFF, 0, 0, 0, 0, 2, 0, 0, 1), 1, w);
        // full scale music and speech overflow into clip, positive left and negative right
        add_row(mk(TypeMusic, 16'hFFFF, 0, 0, 0, 0, 2, 32767, -32768, 0));
        add_row(mk(TypeSpeech, 16'hFFFF, 0, 0, 0, 0, 2, 32767, -32768, 0));
        add_row(mk(TypeMusic, 16'hFFFF, 0, 0, 0, 0, 2, 32767, -32768, 1));
        // zero volume and unknown type add nothing
        add_row(mk(TypeSpeech, 0, 0, 0, 0, 0, 2, 32767, 32767, 0));
        add_row(mk(2'd3, 16'hFFFF, 0, 0, 0, 0, 2, 32767, 32767, 1), 1, w);
        // source channel count zero, three and one
        add_row(mk(TypeMusic, 16'hFFFF, 0, 0, 0, 0, 0, 30000, 30000, 1), 1, w);
        add_row(mk(TypeMusic, 16'hFFFF, 0, 0, 0, 0, 3, -30000, 30000, 1));
        add_row(mk(TypeMusic, 16'h8000, 0, 0, 0, 0, 1, 1000, 1000, 1));
        // effect at listener, left, right, far away, coordinate extremes
        add_row(mk(TypeEffect, 16'hFFFF, 5, 5, 5, 5, 2, 32767, 32767, 1));
        add_row(mk(TypeEffect, 16'hFFFF, -300, 0, 0, 0, 2, 20000, 20000, 1));
        add_row(mk(TypeEffect, 16'hFFFF, 700, 100, 0, 0, 2, 20000, -20000, 1));
        add_row(mk(TypeEffect, 16'hFFFF, 8388607, 8388607, -8388608, -8388608,
                   2, 32767, 32767, 1), 1, w);
        add_row(mk(TypeEffect, 16'hFFFF, -8388608, 0, 8388607, 0, 2, -1, -1, 1));
        add_row(mk(TypeEffect, 16'h1234, 2900, -2900, 0, 0, 2, 12345, -12345, 1));
        // many full-scale sources drive the accumulator hard
        for (int i = 0; i < 6; i++)
            add_row(mk(TypeSpeech, 16'hFFFF, 0, 0, 0, 0, 2, -32768, 32767,
                       int'(i == 5)));
        foreach (dir_rows[i]) begin
            if (dir_rows[i].known) begin
                send(dir_rows[i].it);
                if (frames_due.size() != 0 && frames_due[$] != dir_rows[i].want) begin
                    mismatches++;
                    $display("predictor disagrees with table row %0d", i);
                end
            end else send(dir_rows[i].it);
        end
        drain();

        // configuration sweeps with random traffic
        for (int ph = 0; ph < 8; ph++) begin
            write_reg(RegWMusic,  ph == 0 ? 16'h0000 : ph == 1 ? 16'hFFFF : 16'($urandom));
            write_reg(RegWEffect, ph == 0 ? 16'hFFFF : ph == 1 ? 16'h0000 : 16'($urandom));
            write_reg(RegWSpeech, ph == 2 ? 16'hFFFF : 16'($urandom));
            write_reg(RegOutCh, 16'(ph % 4));
            if (ph == 3) hold_off = 1;
            for (int k = 0; k < 100; k++) begin
                if (ph == 7 && k == 60) quiet = 1;
                send(rand_item(k % 4 == 3));
            end
            // close the frame so the next write sees empty accumulators
            send(mk(TypeMusic, 0, 0, 0, 0, 0, 1, 0, 0, 1));
            drain();
        end

        $display("%0d source beats sent, %0d frames checked across 9 register settings",
                 beats_sent, frames_seen);
        if (mismatches == 0 && frames_due.size() == 0)
            $display("[spatial_audio_mixer_unit] OK");
        else
            $display("[spatial_audio_mixer_unit] ERROR");
        $finish;
    end
endmodule
